FILE: design/tfidf_pkg.sv
`default_nettype none
package tfidf_pkg;

  localparam int MAX_DOCS    = 256;
  localparam int NUM_WORDS   = 1024;
  localparam int MAX_DOC_LEN = 512;

  localparam int DOC_W  = 8;
  localparam int WORD_W = 10;
  localparam int ADDR_W = DOC_W + WORD_W;
  localparam int CNT_W  = 10;
  localparam int TOT_W  = 10;
  localparam int DF_W   = 9;
  localparam int SEEN_W = 9;
  localparam int Q_W    = 19;
  localparam int LOG_W  = 28;
  localparam int NUM_W  = 29;

  localparam logic [31:0]    LN2_Q32 = 32'd2977044472;
  localparam logic [Q_W-1:0] Q16_MAX = 19'd524287;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;
  localparam logic [1:0] ST_UNDEF = 2'd3;

  localparam logic REG_SMOOTH = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_EXEC, S_LOG_INIT, S_LOG_MUL, S_LOG_NORM,
    S_LN_MUL, S_LN_FIN, S_TF_MUL, S_DIV_INIT, S_DIV, S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: design/tfidf_term_weighting_top.sv
// TF-IDF term weighting engine.
// Input channel (in_valid/in_ready) carries one request: req_type selects
// add token, query weight or clear; doc_index and word_id name the entry.
// Output channel (out_valid/out_ready) returns one result per request:
// tfidf_value and idf_value in unsigned Q3.16 plus a status code.
// The block takes one request at a time; in_ready is high only when idle.
// Add, unknown request, or query with undefined idf: the request passes
// the fetch, execute and done states, then the block is idle again.
// Query: one shared 32x32 multiplier runs two base-2 logarithms of 24
// squarings each, the ln scale and the tf product, then a radix-2
// divider produces 29 quotient bits. A query on an empty document
// ends after the ln scale, with no tf product or division.
// Clear and reset: a sweep zeroes all stores, one address a cycle,
// over 262144 addresses; in_ready stays low meanwhile (APB writes still land).
// A clear request returns its result once the sweep is done.
// A result waits in the output register while out_ready is low; a new
// request is still taken, and its result holds until the register frees.
// The smoothing bit sits at APB byte address 0 and keeps its value over clear.
`default_nettype none
module tfidf_term_weighting_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  req_type,
  input  wire logic [tfidf_pkg::DOC_W-1:0] doc_index,
  input  wire logic [tfidf_pkg::WORD_W-1:0] word_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tfidf_pkg::Q_W-1:0]        tfidf_value,
  output logic [tfidf_pkg::Q_W-1:0]        idf_value,
  output logic [1:0]                       status,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tfidf_pkg::*;

  state_t state, state_next;

  // Stores
  logic [CNT_W-1:0] tc_mem [MAX_DOCS*NUM_WORDS];
  logic [TOT_W-1:0] dt_mem [MAX_DOCS];
  logic [DF_W-1:0]  df_mem [NUM_WORDS];
  logic [CNT_W-1:0] tc_q;
  logic [TOT_W-1:0] dt_q;
  logic [DF_W-1:0]  df_q;
  logic [SEEN_W-1:0] docs_seen;
  logic smooth;

  // Request latch
  logic [1:0]        req_q;
  logic [DOC_W-1:0]  doc_q;
  logic [WORD_W-1:0] word_q;
  logic              clr_pend;
  logic [ADDR_W-1:0] sweep;

  // Shared arithmetic
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic [31:0]      y;
  logic [LOG_W-1:0] r, rn, rdf;
  logic [4:0]       bit_idx;
  logic             lsel, neg;
  logic [Q_W-1:0]   idf_r;
  logic [NUM_W-1:0] quo;
  logic [TOT_W-1:0] rem;

  // Working result
  logic [Q_W-1:0] res_idf;
  logic [1:0]     res_status;

  // Comb helpers
  logic             tc_we, dt_we, df_we;
  logic [ADDR_W-1:0] tc_waddr;
  logic [CNT_W-1:0]  tc_wdata;
  logic [DOC_W-1:0]  dt_waddr;
  logic [TOT_W-1:0]  dt_wdata;
  logic [WORD_W-1:0] df_waddr;
  logic [DF_W-1:0]   df_wdata;
  logic [TOT_W-1:0]  df_sum;
  logic [TOT_W-1:0]  log_x;
  logic [3:0]        log_k;
  logic [32:0]       sq;
  logic [LOG_W-1:0]  mag;
  logic [60:0]       v, vr;
  logic [20:0]       qf;
  logic [TOT_W:0]    dsh;
  logic              load_out;

  localparam logic [60:0] ONE56 = 61'(1) << 56;
  localparam logic [60:0] HALF40 = 61'(1) << 39;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_SMOOTH) ? {31'd0, smooth} : 32'd0;
  assign in_ready = (state == S_IDLE);
  assign df_sum  = TOT_W'(df_q) + TOT_W'(smooth);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SMOOTH) begin
      smooth <= pwdata[0];
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tc_we) begin
      tc_mem[tc_waddr] <= tc_wdata;
    end
    tc_q <= tc_mem[{doc_q, word_q}];
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      dt_mem[dt_waddr] <= dt_wdata;
    end
    dt_q <= dt_mem[doc_q];
  end

  always_ff @(posedge clk) begin
    if (df_we) begin
      df_mem[df_waddr] <= df_wdata;
    end
    df_q <= df_mem[word_q];
  end

  // Log operand and leading-one position
  always_comb begin
    log_x = lsel ? df_sum : TOT_W'(docs_seen);
    log_k = 4'd0;
    for (int j = 0; j < TOT_W; j++) begin
      if (log_x[j]) begin
        log_k = 4'(j);
      end
    end
  end

  assign sq  = prod[63:31];
  assign mag = neg ? (rdf - rn) : (rn - rdf);
  assign dsh = {rem, quo[NUM_W-1]};

  always_comb begin
    if (!neg) begin
      v = ONE56 + prod[60:0];
    end else if (prod[60:0] > ONE56) begin
      v = '0;
    end else begin
      v = ONE56 - prod[60:0];
    end
    vr = v + HALF40;
    qf = vr[60:40];
  end

  // Multiplier operand select
  always_comb begin
    unique case (state)
      S_LOG_MUL: begin
        mul_a = y;
        mul_b = y;
      end
      S_LN_MUL: begin
        mul_a = 32'(mag);
        mul_b = LN2_Q32;
      end
      default: begin
        mul_a = 32'(tc_q);
        mul_b = 32'(idf_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store writes
  always_comb begin
    state_next = state;
    tc_we = 1'b0;
    dt_we = 1'b0;
    df_we = 1'b0;
    tc_waddr = sweep;
    tc_wdata = '0;
    dt_waddr = sweep[DOC_W-1:0];
    dt_wdata = '0;
    df_waddr = sweep[WORD_W-1:0];
    df_wdata = '0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FETCH;
      end
      S_CLEAR: begin
        tc_we = 1'b1;
        dt_we = 1'b1;
        df_we = 1'b1;
        if (sweep == '1) state_next = clr_pend ? S_DONE : S_IDLE;
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        priority if (req_q == REQ_CLEAR) begin
          state_next = S_CLEAR;
        end else if (req_q == REQ_ADD) begin
          state_next = S_DONE;
          if (dt_q < TOT_W'(MAX_DOC_LEN)) begin
            tc_we = 1'b1;
            tc_waddr = {doc_q, word_q};
            tc_wdata = tc_q + 1'b1;
            dt_we = 1'b1;
            dt_waddr = doc_q;
            dt_wdata = dt_q + 1'b1;
            df_we = (tc_q == '0);
            df_waddr = word_q;
            df_wdata = df_q + 1'b1;
          end
        end else if (req_q == REQ_QUERY && docs_seen != '0 && df_sum != '0) begin
          state_next = S_LOG_INIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOG_INIT: state_next = S_LOG_MUL;
      S_LOG_MUL:  state_next = S_LOG_NORM;
      S_LOG_NORM: begin
        if (bit_idx != '0) state_next = S_LOG_MUL;
        else if (!lsel)    state_next = S_LOG_INIT;
        else               state_next = S_LN_MUL;
      end
      S_LN_MUL: state_next = S_LN_FIN;
      S_LN_FIN: state_next = (dt_q == '0) ? S_DONE : S_TF_MUL;
      S_TF_MUL: state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV: begin
        if (bit_idx == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      docs_seen <= '0;
      clr_pend  <= 1'b0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid) begin
        clr_pend <= 1'b0;
      end
      if (state == S_CLEAR) begin
        sweep <= sweep + 1'b1;
      end
      if (state == S_EXEC) begin
        if (req_q == REQ_CLEAR) begin
          docs_seen <= '0;
          clr_pend  <= 1'b1;
          sweep     <= '0;
        end else if (req_q == REQ_ADD && dt_q == '0) begin
          docs_seen <= docs_seen + 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_q  <= req_type;
      doc_q  <= doc_index;
      word_q <= word_id;
    end
    unique case (state)
      S_EXEC: begin
        res_idf <= '0;
        lsel    <= 1'b0;
        priority if (req_q == REQ_CLEAR) begin
          res_status <= ST_OK;
        end else if (req_q == REQ_ADD) begin
          res_status <= (dt_q >= TOT_W'(MAX_DOC_LEN)) ? ST_SAT : ST_OK;
        end else if (req_q == REQ_QUERY) begin
          res_status <= (docs_seen == '0 || df_sum == '0) ? ST_UNDEF : ST_OK;
        end else begin
          res_status <= ST_RANGE;
        end
      end
      S_LOG_INIT: begin
        y       <= 32'(log_x) << (5'd31 - 5'(log_k));
        r       <= LOG_W'(log_k) << 24;
        bit_idx <= 5'd23;
      end
      S_LOG_NORM: begin
        if (sq[32]) begin
          y <= sq[32:1];
          r <= r | (LOG_W'(1) << bit_idx);
        end else begin
          y <= sq[31:0];
        end
        if (bit_idx != '0) begin
          bit_idx <= bit_idx - 1'b1;
        end else if (!lsel) begin
          rn   <= sq[32] ? (r | LOG_W'(1)) : r;
          lsel <= 1'b1;
        end else begin
          rdf <= sq[32] ? (r | LOG_W'(1)) : r;
          neg <= (rn < (sq[32] ? (r | LOG_W'(1)) : r));
        end
      end
      S_LN_FIN: begin
        idf_r   <= (qf > 21'(Q16_MAX)) ? Q16_MAX : qf[Q_W-1:0];
        res_idf <= (qf > 21'(Q16_MAX)) ? Q16_MAX : qf[Q_W-1:0];
        if (dt_q == '0) res_status <= ST_UNDEF;
      end
      S_DIV_INIT: begin
        quo     <= prod[NUM_W-1:0] + NUM_W'(dt_q >> 1);
        rem     <= '0;
        bit_idx <= 5'(NUM_W - 1);
      end
      S_DIV: begin
        if (dsh >= {1'b0, dt_q}) begin
          rem <= TOT_W'(dsh - {1'b0, dt_q});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= dsh[TOT_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        if (bit_idx != '0) bit_idx <= bit_idx - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register; a finished query's quotient is taken here
  always_ff @(posedge clk) begin
    if (load_out) begin
      tfidf_value <= (req_q == REQ_QUERY && res_status == ST_OK)
                     ? ((quo[NUM_W-1:Q_W] != '0) ? Q16_MAX : quo[Q_W-1:0]) : '0;
      idf_value   <= res_idf;
      status      <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_tf_le_idf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tfidf_value <= idf_value)
    else $error("tfidf above idf");
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE || status == ST_SAT)
      |-> tfidf_value == '0 && idf_value == '0)
    else $error("nonzero value with error status");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    docs_seen <= SEEN_W'(MAX_DOCS))
    else $error("docs_seen beyond document count");
`endif

endmodule
`default_nettype wire
